### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrc assertion failed");

// next-cycle implication
`define LRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrc assertion failed");

`endif

### rtl/lrc_pkg.sv
// Types and constants for the replica count pipeline.
// No dependencies.
package lrc_pkg;

    localparam int RHS_W  = 128;
    localparam int ROOT_W = 64;
    localparam int REM_W  = 67;
    localparam int D_W    = 64;

    typedef struct packed {
        logic signed [31:0] cell_00;
        logic signed [31:0] cell_01;
        logic signed [31:0] cell_10;
        logic signed [31:0] cell_11;
        logic signed [31:0] radius;
    } in_t;

    typedef struct packed {
        logic [15:0] count_0;
        logic [15:0] count_1;
        logic [33:0] total_replicas;
        logic        degenerate;
        logic        saturated;
    } out_t;

    typedef struct packed {
        logic             valid;
        logic             deg;
        logic [D_W-1:0]   d;
        logic [RHS_W-1:0] rhs0;
        logic [RHS_W-1:0] rhs1;
    } front_t;

    function automatic logic [31:0] abs32(logic signed [31:0] a);
        abs32 = a[31] ? (~a + 32'd1) : a;
    endfunction

endpackage

### rtl/lrc_front.sv
// Front pipeline: determinant, squared lengths and wide products r^2*S.
// Depends on lrc_pkg.
module lrc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          use_columns,
    input  logic          in_valid,
    input  lrc_pkg::in_t  in_data,
    output lrc_pkg::front_t front
);
    import lrc_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [63:0] pa_reg, pb_reg;
    logic [63:0] sq00_reg, sq01_reg, sq10_reg, sq11_reg, sqr_reg;

    logic [63:0] d2_reg, s0_reg, s1_reg;
    logic [62:0] r2_reg;
    logic        deg2_reg;

    logic [63:0] d3_reg;
    logic        deg3_reg;
    logic [63:0] ll0_reg, lh0_reg, ll1_reg, lh1_reg;
    logic [62:0] hl0_reg, hh0_reg, hl1_reg, hh1_reg;

    logic [63:0]      d4_reg;
    logic             deg4_reg;
    logic [RHS_W-1:0] rhs0_reg, rhs1_reg;

    logic [31:0] m00, m01, m10, m11, mr;
    logic signed [64:0] det;
    logic [63:0] d_next;
    logic [63:0] s0_next, s1_next;

    assign m00 = abs32(in_data.cell_00);
    assign m01 = abs32(in_data.cell_01);
    assign m10 = abs32(in_data.cell_10);
    assign m11 = abs32(in_data.cell_11);
    assign mr  = abs32(in_data.radius);

    assign det    = {pa_reg[63], pa_reg} - {pb_reg[63], pb_reg};
    assign d_next = det[64] ? 64'(~det + 65'sd1) : det[63:0];

    always_comb
    begin
        if (use_columns)
        begin
            s0_next = sq01_reg + sq11_reg;
            s1_next = sq00_reg + sq10_reg;
        end
        else
        begin
            s0_next = sq10_reg + sq11_reg;
            s1_next = sq00_reg + sq01_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg   <= in_data.cell_00 * in_data.cell_11;
            pb_reg   <= in_data.cell_01 * in_data.cell_10;
            sq00_reg <= m00 * m00;
            sq01_reg <= m01 * m01;
            sq10_reg <= m10 * m10;
            sq11_reg <= m11 * m11;
            sqr_reg  <= mr * mr;

            d2_reg   <= d_next;
            deg2_reg <= (det == 65'sd0);
            s0_reg   <= s0_next;
            s1_reg   <= s1_next;
            r2_reg   <= sqr_reg[62:0];

            d3_reg   <= d2_reg;
            deg3_reg <= deg2_reg;
            ll0_reg  <= r2_reg[31:0] * s0_reg[31:0];
            lh0_reg  <= r2_reg[31:0] * s0_reg[63:32];
            hl0_reg  <= 63'(r2_reg[62:32] * s0_reg[31:0]);
            hh0_reg  <= 63'(r2_reg[62:32] * s0_reg[63:32]);
            ll1_reg  <= r2_reg[31:0] * s1_reg[31:0];
            lh1_reg  <= r2_reg[31:0] * s1_reg[63:32];
            hl1_reg  <= 63'(r2_reg[62:32] * s1_reg[31:0]);
            hh1_reg  <= 63'(r2_reg[62:32] * s1_reg[63:32]);

            d4_reg   <= d3_reg;
            deg4_reg <= deg3_reg;
            rhs0_reg <= RHS_W'(ll0_reg) + (RHS_W'(lh0_reg) << 32)
                      + (RHS_W'(hl0_reg) << 32) + (RHS_W'(hh0_reg) << 64);
            rhs1_reg <= RHS_W'(ll1_reg) + (RHS_W'(lh1_reg) << 32)
                      + (RHS_W'(hl1_reg) << 32) + (RHS_W'(hh1_reg) << 64);
        end
    end

    assign front.valid = v4_reg;
    assign front.deg   = deg4_reg;
    assign front.d     = d4_reg;
    assign front.rhs0  = rhs0_reg;
    assign front.rhs1  = rhs1_reg;

endmodule

### rtl/lrc_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on lrc_pkg.
module lrc_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [lrc_pkg::RHS_W-1:0] value,
    input  logic [SIDE_W-1:0]         side_in,
    output logic [lrc_pkg::ROOT_W-1:0] root,
    output logic                      inexact,
    output logic [SIDE_W-1:0]         side_out
);
    import lrc_pkg::*;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RHS_W-1:0]  val_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        logic [REM_W-1:0]  rem_in, rem2, trial;
        logic [ROOT_W-1:0] root_in;
        logic [RHS_W-1:0]  val_in;
        logic [SIDE_W-1:0] side_k;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = value;
            assign side_k  = side_in;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign val_in  = val_reg[k-1];
            assign side_k  = side_reg[k-1];
        end

        assign rem2  = {rem_in[REM_W-3:0], val_in[RHS_W-1:RHS_W-2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (rem2 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[k] <= '0;
            else if (en)
                side_reg[k] <= side_k;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem2 - trial) : rem2;
                root_reg[k] <= {root_in[ROOT_W-2:0], ge};
                val_reg[k]  <= {val_in[RHS_W-3:0], 2'b00};
            end
        end
    end

    assign root     = root_reg[ROOT_W-1];
    assign inexact  = (rem_reg[ROOT_W-1] != '0);
    assign side_out = side_reg[ROOT_W-1];

endmodule

### rtl/lrc_div.sv
// Pipelined ceiling divide of the covering length by the area, with clipping.
// Depends on lrc_pkg.
module lrc_div #(
    parameter int COUNT_MAX = 65535,
    parameter int SIDE_W    = 1,
    parameter int QW        = $clog2(COUNT_MAX + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [lrc_pkg::ROOT_W-1:0] root,
    input  logic                       inexact,
    input  logic [lrc_pkg::D_W-1:0]    d,
    input  logic [SIDE_W-1:0]          side_in,
    output logic [QW-1:0]              count,
    output logic                       sat,
    output logic [SIDE_W-1:0]          side_out
);
    import lrc_pkg::*;

    // stage 0 prepares x = ceil(sqrt) - 1; stages 1..QW are restoring steps
    logic [D_W-1:0]    r_reg    [QW+1];
    logic [QW-1:0]     xl_reg   [QW+1];
    logic [QW-1:0]     q_reg    [QW+1];
    logic [D_W-1:0]    d_reg    [QW+1];
    logic              zero_reg [QW+1];
    logic              ovf_reg  [QW+1];
    logic [SIDE_W-1:0] side_reg [QW+1];

    logic [ROOT_W-1:0] x;
    logic [ROOT_W-1:0] x_hi;
    logic              ovf0;

    assign x    = inexact ? root : (root - ROOT_W'(1));
    assign x_hi = x >> QW;
    assign ovf0 = (x_hi >= d);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg[0] <= '0;
        else if (en)
            side_reg[0] <= side_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= ovf0 ? '0 : x_hi;
            xl_reg[0]   <= x[QW-1:0];
            q_reg[0]    <= '0;
            d_reg[0]    <= d;
            zero_reg[0] <= (root == '0) && !inexact;
            ovf_reg[0]  <= ovf0;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [D_W:0] r2;
        logic         ge;

        assign r2 = {r_reg[k-1], xl_reg[k-1][QW-1]};
        assign ge = (r2 >= {1'b0, d_reg[k-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[k] <= '0;
            else if (en)
                side_reg[k] <= side_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]    <= ge ? D_W'(r2 - {1'b0, d_reg[k-1]}) : r2[D_W-1:0];
                xl_reg[k]   <= {xl_reg[k-1][QW-2:0], 1'b0};
                q_reg[k]    <= {q_reg[k-1][QW-2:0], ge};
                d_reg[k]    <= d_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (zero_reg[QW])
        begin
            count = '0;
            sat   = 1'b0;
        end
        else if (ovf_reg[QW] || (q_reg[QW] >= QW'(COUNT_MAX)))
        begin
            count = QW'(COUNT_MAX);
            sat   = 1'b1;
        end
        else
        begin
            count = q_reg[QW] + QW'(1);
            sat   = 1'b0;
        end
    end

    assign side_out = side_reg[QW];

endmodule

### rtl/lattice_replicas_to_cover_sphere.sv
// Replica counts for a cutoff sphere in a 2D periodic cell. Takes one request
// per cycle while the output is not stalled; 4 front stages, 64 root stages,
// 1 + clog2(COUNT_MAX+1) divide stages, 1 output stage. A stalled output freezes the pipe.
module lattice_replicas_to_cover_sphere #(
    parameter int COUNT_MAX = 65535
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lrc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output lrc_pkg::out_t out_data,
    input  logic          cfg_write_en,
    input  logic          cfg_write_data
);
    import lrc_pkg::*;

    localparam int QW = $clog2(COUNT_MAX + 1);
    localparam int NW = (QW > 16) ? QW : 16;
    localparam int PW = (2 * QW + 2 > 34) ? (2 * QW + 2) : 34;

    logic   use_columns_reg;
    logic   out_valid_reg;
    out_t   out_data_reg;
    logic   en;
    front_t front;

    logic [ROOT_W-1:0] root0, root1;
    logic              inex0, inex1;
    logic [D_W+1:0]    sq_side0;
    logic [D_W:0]      sq_side1;
    logic [QW-1:0]     n0, n1;
    logic              sat0, sat1;
    logic [1:0]        dv_side0;
    logic              dv_side1;

    logic [NW-1:0] n0_w, n1_w;
    logic [PW-1:0] prod;
    out_t          out_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            use_columns_reg <= 1'b0;
        else if (cfg_write_en)
            use_columns_reg <= cfg_write_data;
    end

    lrc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .use_columns (use_columns_reg),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .front       (front)
    );

    lrc_isqrt #(.SIDE_W(D_W + 2)) u_sqrt0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .value    (front.rhs0),
        .side_in  ({front.valid, front.deg, front.d}),
        .root     (root0),
        .inexact  (inex0),
        .side_out (sq_side0)
    );

    lrc_isqrt #(.SIDE_W(D_W + 1)) u_sqrt1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .value    (front.rhs1),
        .side_in  ({front.valid, front.d}),
        .root     (root1),
        .inexact  (inex1),
        .side_out (sq_side1)
    );

    lrc_div #(.COUNT_MAX(COUNT_MAX), .SIDE_W(2)) u_div0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .root     (root0),
        .inexact  (inex0),
        .d        (sq_side0[D_W-1:0]),
        .side_in  (sq_side0[D_W+1:D_W]),
        .count    (n0),
        .sat      (sat0),
        .side_out (dv_side0)
    );

    lrc_div #(.COUNT_MAX(COUNT_MAX), .SIDE_W(1)) u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .root     (root1),
        .inexact  (inex1),
        .d        (sq_side1[D_W-1:0]),
        .side_in  (sq_side1[D_W]),
        .count    (n1),
        .sat      (sat1),
        .side_out (dv_side1)
    );

    assign n0_w = NW'(n0);
    assign n1_w = NW'(n1);
    assign prod = PW'({n0, 1'b1}) * PW'({n1, 1'b1});

    always_comb
    begin
        if (dv_side0[0])
        begin
            out_next.count_0        = '0;
            out_next.count_1        = '0;
            out_next.total_replicas = 34'd1;
            out_next.degenerate     = 1'b1;
            out_next.saturated      = 1'b0;
        end
        else
        begin
            out_next.count_0        = n0_w[15:0];
            out_next.count_1        = n1_w[15:0];
            out_next.total_replicas = prod[33:0];
            out_next.degenerate     = 1'b0;
            out_next.saturated      = sat0 || sat1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_side0[1];
    end

    always_ff @(posedge clk)
    begin
        if (en && dv_side0[1])
            out_data_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`include "assert_macros.svh"

    `LRC_ASSERT_IMP(a_lanes_aligned, clk, rst_n, 1'b1, dv_side0[1] == dv_side1)
    `LRC_ASSERT_IMP(a_deg_no_sat, clk, rst_n, out_valid && out_data.degenerate,
        !out_data.saturated && out_data.total_replicas == 34'd1)
    `LRC_ASSERT_NEXT(a_output_taken, clk, rst_n, !out_valid && en && dv_side0[1], out_valid)

endmodule

### test/lrc_checker.sv
// Scoreboard for the replica count pipeline: predicts each accepted request and
// compares it with the results in order. Depends on lrc_pkg.
`timescale 1ns / 1ps

module lrc_checker #(
    parameter int COUNT_MAX = 65535
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  lrc_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  lrc_pkg::out_t out_data,
    input  logic          cfg_write_en,
    input  logic          cfg_write_data,
    output int            errors,
    output int            pending,
    output int            results
);
    import lrc_pkg::*;

    logic  col_mode;
    out_t  expected_q[$];

    function automatic logic [63:0] square(logic signed [31:0] v);
        logic [63:0] m;
        m = v[31] ? 64'(-64'(v)) : 64'(v);
        return m * m;
    endfunction

    // smallest n in [0, COUNT_MAX] with (n*d)^2 >= r2*s, or COUNT_MAX+1
    function automatic logic [31:0] cover_n(logic [63:0] r2, logic [63:0] s, logic [63:0] d);
        logic [255:0] rhs, nd;
        logic [31:0]  lo, hi, mid;
        rhs = 256'(r2) * 256'(s);
        lo = 0;
        hi = COUNT_MAX + 1;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            nd = 256'(mid) * 256'(d);
            if (nd * nd >= rhs)
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic out_t predict_replicas(in_t x, logic cols);
        out_t        r;
        logic signed [65:0] det;
        logic [63:0] d, s0, s1, r2;
        logic [31:0] n0, n1;
        logic [63:0] tot;
        r = '0;
        det = 66'(x.cell_00) * 66'(x.cell_11) - 66'(x.cell_01) * 66'(x.cell_10);
        d = det[65] ? 64'(-det) : 64'(det);
        if (d == 0)
        begin
            r.total_replicas = 1;
            r.degenerate = 1;
            return r;
        end
        if (cols)
        begin
            s0 = square(x.cell_01) + square(x.cell_11);
            s1 = square(x.cell_00) + square(x.cell_10);
        end
        else
        begin
            s0 = square(x.cell_10) + square(x.cell_11);
            s1 = square(x.cell_00) + square(x.cell_01);
        end
        r2 = square(x.radius);
        n0 = cover_n(r2, s0, d);
        n1 = cover_n(r2, s1, d);
        if (n0 > COUNT_MAX)
        begin
            n0 = COUNT_MAX;
            r.saturated = 1;
        end
        if (n1 > COUNT_MAX)
        begin
            n1 = COUNT_MAX;
            r.saturated = 1;
        end
        tot = (2 * 64'(n0) + 1) * (2 * 64'(n1) + 1);
        r.count_0 = n0[15:0];
        r.count_1 = n1[15:0];
        r.total_replicas = tot[33:0];
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_t e;
        if (!rst_n)
        begin
            col_mode <= 1'b0;
            errors = 0;
            results = 0;
            expected_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_q.push_back(predict_replicas(in_data, col_mode));
            if (out_valid && out_ready)
            begin
                results++;
                if (expected_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (out_data.count_0 !== e.count_0)
                    begin
                        $error("count_0 exp %0d got %0d", e.count_0, out_data.count_0);
                        errors++;
                    end
                    if (out_data.count_1 !== e.count_1)
                    begin
                        $error("count_1 exp %0d got %0d", e.count_1, out_data.count_1);
                        errors++;
                    end
                    if (out_data.total_replicas !== e.total_replicas)
                    begin
                        $error("total_replicas exp %0d got %0d",
                               e.total_replicas, out_data.total_replicas);
                        errors++;
                    end
                    if (out_data.degenerate !== e.degenerate)
                    begin
                        $error("degenerate exp %0d got %0d", e.degenerate, out_data.degenerate);
                        errors++;
                    end
                    if (out_data.saturated !== e.saturated)
                    begin
                        $error("saturated exp %0d got %0d", e.saturated, out_data.saturated);
                        errors++;
                    end
                end
            end
            if (cfg_write_en)
                col_mode <= cfg_write_data;
        end
    end

endmodule

### test/testbench.sv
// Top of the replica count testbench: clock, reset, requests, mode writes and
// verdict. Depends on lrc_pkg, lrc_checker and lattice_replicas_to_cover_sphere.
`timescale 1ns / 1ps

module testbench;
    import lrc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1330;
    localparam int PIPE_DRAIN  = 100;
    localparam int HOLD_AT     = 270;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    logic  clk, rst_n;
    logic  in_valid, in_ready, out_valid, out_ready;
    in_t   in_data;
    out_t  out_data;
    logic  cfg_write_en, cfg_write_data;
    int    errors, pending, results, cycles, sent;
    logic  quiet;

    lattice_replicas_to_cover_sphere uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
    );

    lrc_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
        .errors(errors), .pending(pending), .results(results)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: short random holds, plus one long hold once enough requests went in
    initial
    begin
        bit long_done;
        long_done = 0;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_done && sent >= HOLD_AT)
            begin
                long_done = 1;
                out_ready <= 0;
                repeat (400) @(posedge clk);
                out_ready <= 1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ready <= 1;
            end
            else
                out_ready <= 1;
        end
    end

    task automatic push_request(in_t x);
        in_valid <= 1;
        in_data <= x;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic write_mode(logic v);
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_write_en <= 1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] near_unit();
        return $signed(32'($urandom_range(0, 4 * 65536))) - 2 * 65536;
    endfunction

    function automatic in_t random_request();
        in_t x;
        int  k;
        k = $urandom_range(0, 9);
        x.cell_00 = near_unit();
        x.cell_01 = near_unit();
        x.cell_10 = near_unit();
        x.cell_11 = near_unit();
        x.radius  = $signed(32'($urandom_range(0, 64 * 65536))) - 32 * 65536;
        case (k)
            0, 1:
            begin
                x.cell_00 = $urandom;
                x.cell_01 = $urandom;
                x.cell_10 = $urandom;
                x.cell_11 = $urandom;
                x.radius  = $urandom;
            end
            2: x.radius = $urandom;
            3:
            begin
                x.cell_10 = x.cell_00 * 2;
                x.cell_11 = x.cell_01 * 2;
            end
            4:
            begin
                x.cell_01 = 0;
                x.cell_10 = 0;
            end
            5: x.radius = $signed(32'($urandom_range(0, 3)));
            default: ;
        endcase
        return x;
    endfunction

    initial
    begin
        in_t directed[$];
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_write_en = 0;
        cfg_write_data = 0;
        sent = 0;
        quiet = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        directed.push_back('{ONE, 0, 0, ONE, ONE});
        directed.push_back('{ONE, 0, 0, ONE, 0});
        directed.push_back('{0, 0, 0, 0, ONE});
        directed.push_back('{ONE, 2 * ONE, 2 * ONE, 4 * ONE, ONE});
        directed.push_back('{SMAX, SMAX, SMAX, SMAX, SMAX});
        directed.push_back('{SMIN, SMIN, SMIN, SMIN, SMIN});
        directed.push_back('{SMIN, SMIN, SMAX, SMIN, SMIN});
        directed.push_back('{SMIN, SMIN, SMIN, SMAX, SMAX});
        directed.push_back('{32'sd1, 0, 0, 32'sd1, SMAX});
        directed.push_back('{32'sd1, 0, 0, 32'sd1, SMIN});
        directed.push_back('{0, ONE, ONE, 0, 3 * ONE});
        directed.push_back('{ONE, 3 * ONE, 0, ONE / 2, 5 * ONE});
        directed.push_back('{-ONE, ONE / 3, 2 * ONE, -ONE, -7 * ONE});
        directed.push_back('{-1, -1, -1, 32'sd1, -1});
        directed.push_back('{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678,
                             32'shedcb_a987, 32'sh0f0f_0f0f});

        write_mode(0);
        foreach (directed[i])
            push_request(directed[i]);
        write_mode(1);
        foreach (directed[i])
            push_request(directed[i]);

        for (int p = 0; p < 6; p++)
        begin
            write_mode(p[0]);
            for (int i = 0; i < N_RANDOM / 6; i++)
            begin
                if (p == 5 && i == N_RANDOM / 12)
                    quiet = 1;
                push_request(random_request());
            end
        end
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);

        $display("%0d requests sent in both vector modes, %0d results checked", sent, results);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
